/* sv/sorted_insert_priority_queue_core_assert.svh */
// Assertion macros used by the checker file of the priority queue core.
// No dependencies; included by the checker only.
`ifndef SORTED_INSERT_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_CORE_ASSERT_SVH

// Checked on every rising edge outside of reset.
`define SIPQ_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define SIPQ_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/sipq_pkg.sv */
// Package for the sorted insertion priority queue: item types, codes, defaults.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sipq_pkg;

  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int VAL_W           = 32;
  localparam int OCC_W           = 4;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DEQ
  } state_t;

  typedef struct packed {
    op_t                     opcode;
    logic signed [VAL_W-1:0] item_value;
    logic signed [VAL_W-1:0] item_priority;
  } cmd_t;

  typedef struct packed {
    status_t                 status;
    logic signed [VAL_W-1:0] out_value;
    logic signed [VAL_W-1:0] out_priority;
    logic [OCC_W-1:0]        occupancy;
  } rsp_t;

  // One stored entry, one RAM word.
  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] prio;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

/* sv/sipq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sipq_ram #(
  parameter  int WIDTH  = 64,
  parameter  int DEPTH  = 8,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* sv/sipq_step.sv */
// Insertion walk step unit: the one priority compare plus the circular slot step-down.
// Depends on sipq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sipq_step #(
  parameter  int DEPTH = sipq_pkg::QUEUE_DEPTH_DEF,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  sipq_pkg::entry_t   rd_entry,   // entry one slot nearer the head
  input  sipq_pkg::entry_t   key,        // entry being inserted
  input  logic               pos_nz,     // walk has not reached the head
  input  logic [IDX_W-1:0]   slot,
  output logic               shift,
  output logic [IDX_W-1:0]   slot_prev
);

  logic gt;

  // strictly greater: equal priorities stay ahead of the new entry
  assign gt    = $signed(rd_entry.prio) > $signed(key.prio);
  assign shift = pos_nz && gt;

  assign slot_prev = (slot == '0) ? IDX_W'(DEPTH - 1) : slot - IDX_W'(1);

endmodule

`default_nettype wire

/* sv/sipq_ctrl.sv */
// Sequencer of the priority queue: command decode, insertion walk, dequeue, result register.
// Depends on sipq_pkg; drives sipq_ram and sipq_step from the top level.
`timescale 1ns / 1ps
`default_nettype none

module sipq_ctrl #(
  parameter  int DEPTH = sipq_pkg::QUEUE_DEPTH_DEF,
  localparam int IDX_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  sipq_pkg::cmd_t            cmd,
  output logic                      done,
  output sipq_pkg::rsp_t            result,
  // RAM
  output logic                      ram_we,
  output logic [IDX_W-1:0]          ram_waddr,
  output sipq_pkg::entry_t          ram_wdata,
  output logic [IDX_W-1:0]          ram_raddr,
  input  sipq_pkg::entry_t          ram_rdata,
  // step unit
  output sipq_pkg::entry_t          step_key,
  output logic                      step_pos_nz,
  output logic [IDX_W-1:0]          step_slot,
  input  logic                      step_shift,
  input  logic [IDX_W-1:0]          step_slot_prev
);

  sipq_pkg::state_t state, state_next;

  logic [IDX_W-1:0] head, head_next;
  logic [IDX_W-1:0] tail, tail_next;
  logic [CNT_W-1:0] count, count_next;
  logic [IDX_W-1:0] pos, pos_next;
  logic [IDX_W-1:0] wr_slot, wr_slot_next;
  logic [IDX_W-1:0] rd_slot, rd_slot_next;
  sipq_pkg::entry_t key, key_next;
  logic             done_next;
  sipq_pkg::rsp_t   result_next;

  logic accept;
  logic full;
  logic empty;
  logic [IDX_W-1:0] tail_prev;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] x);
    wrap_inc = (x == IDX_W'(DEPTH - 1)) ? '0 : x + IDX_W'(1);
  endfunction

  assign busy      = (state != sipq_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign tail_prev = (tail == '0) ? IDX_W'(DEPTH - 1) : tail - IDX_W'(1);

  assign step_key    = key;
  assign step_pos_nz = (pos != '0);
  assign step_slot   = rd_slot;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      sipq_pkg::ST_IDLE: begin
        if (accept) begin
          if (cmd.opcode == sipq_pkg::OP_ENQ) begin
            if (!full) state_next = sipq_pkg::ST_WALK;
          end else begin
            if (!empty) state_next = sipq_pkg::ST_DEQ;
          end
        end
      end
      sipq_pkg::ST_WALK: begin
        if (!step_shift) state_next = sipq_pkg::ST_IDLE;
      end
      sipq_pkg::ST_DEQ: begin
        state_next = sipq_pkg::ST_IDLE;
      end
      default: state_next = sipq_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    head_next    = head;
    tail_next    = tail;
    count_next   = count;
    pos_next     = pos;
    wr_slot_next = wr_slot;
    rd_slot_next = rd_slot;
    key_next     = key;
    done_next    = 1'b0;
    result_next  = result;
    ram_we       = 1'b0;
    ram_waddr    = wr_slot;
    ram_wdata    = key;
    ram_raddr    = head;

    unique case (state)
      sipq_pkg::ST_IDLE: begin
        if (accept) begin
          if (cmd.opcode == sipq_pkg::OP_ENQ) begin
            if (full) begin
              done_next                = 1'b1;
              result_next.status       = sipq_pkg::STATUS_FULL;
              result_next.out_value    = '0;
              result_next.out_priority = '0;
              result_next.occupancy    = sipq_pkg::OCC_W'(count);
            end else begin
              // walk starts at the tail, looking one slot toward the head
              key_next.value = cmd.item_value;
              key_next.prio  = cmd.item_priority;
              pos_next       = IDX_W'(count);
              wr_slot_next   = tail;
              rd_slot_next   = tail_prev;
              ram_raddr      = tail_prev;
            end
          end else begin
            if (empty) begin
              done_next                = 1'b1;
              result_next.status       = sipq_pkg::STATUS_EMPTY;
              result_next.out_value    = '0;
              result_next.out_priority = '0;
              result_next.occupancy    = sipq_pkg::OCC_W'(count);
            end else begin
              ram_raddr = head;
            end
          end
        end
      end
      sipq_pkg::ST_WALK: begin
        ram_we    = 1'b1;
        ram_waddr = wr_slot;
        if (step_shift) begin
          // move the larger entry one slot toward the tail
          ram_wdata    = ram_rdata;
          wr_slot_next = rd_slot;
          rd_slot_next = step_slot_prev;
          ram_raddr    = step_slot_prev;
          pos_next     = pos - IDX_W'(1);
        end else begin
          ram_wdata                = key;
          tail_next                = wrap_inc(tail);
          count_next               = count + CNT_W'(1);
          done_next                = 1'b1;
          result_next.status       = sipq_pkg::STATUS_DONE;
          result_next.out_value    = '0;
          result_next.out_priority = '0;
          result_next.occupancy    = sipq_pkg::OCC_W'(count + CNT_W'(1));
        end
      end
      sipq_pkg::ST_DEQ: begin
        head_next                = wrap_inc(head);
        count_next               = count - CNT_W'(1);
        done_next                = 1'b1;
        result_next.status       = sipq_pkg::STATUS_DONE;
        result_next.out_value    = ram_rdata.value;
        result_next.out_priority = ram_rdata.prio;
        result_next.occupancy    = sipq_pkg::OCC_W'(count - CNT_W'(1));
      end
      default: begin
        done_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sipq_pkg::ST_IDLE;
      head  <= '0;
      tail  <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    pos     <= pos_next;
    wr_slot <= wr_slot_next;
    rd_slot <= rd_slot_next;
    key     <= key_next;
    result  <= result_next;
  end

endmodule

`default_nettype wire

/* sv/sorted_insert_priority_queue_core.sv */
// Top level of the sorted insertion priority queue core.
// Depends on sipq_pkg, sipq_ram, sipq_step, sipq_ctrl.
//
//  channel   ports                  handshake
//  --------  ---------------------  ----------------------------------------
//  command   cmd (cmd_t)            taken at a rising edge with start && !busy
//  result    result (rsp_t)         shown for one cycle while done is high
//
// Work per item, from the accept edge until busy is low again:
//   enqueue:  one walk step per stored entry with a larger priority, each moved
//             one slot toward the tail (one RAM read/write per step), then a step that writes the new entry
//   dequeue:  one registered RAM read of the head slot
//   rejected enqueue (full) or dequeue (empty): answered from idle, busy stays low
// The insertion walk does one compare and one shifted entry per
// cycle through the single RAM write port.
// The result strobe comes in the cycle after the last step; busy is already low
// then, so the next item may be accepted in the strobe cycle.
// Reset (rst, synchronous) empties the queue; store contents are left as is.
// The result side has no stall: a result is valid for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module sorted_insert_priority_queue_core #(
  parameter  int QUEUE_DEPTH = sipq_pkg::QUEUE_DEPTH_DEF,
  localparam int IDX_W       = $clog2(QUEUE_DEPTH)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  sipq_pkg::cmd_t cmd,
  output logic           done,
  output sipq_pkg::rsp_t result
);

  // entry store port
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  sipq_pkg::entry_t ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  sipq_pkg::entry_t ram_rdata;

  // step unit
  sipq_pkg::entry_t step_key;
  logic             step_pos_nz;
  logic [IDX_W-1:0] step_slot;
  logic             step_shift;
  logic [IDX_W-1:0] step_slot_prev;

  // Sequencer: decodes the command, runs the walk, registers the result.
  sipq_ctrl #(
    .DEPTH(QUEUE_DEPTH)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .cmd            (cmd),
    .done           (done),
    .result         (result),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .step_key       (step_key),
    .step_pos_nz    (step_pos_nz),
    .step_slot      (step_slot),
    .step_shift     (step_shift),
    .step_slot_prev (step_slot_prev)
  );

  // Single compare: is the entry nearer the head larger than the new one?
  sipq_step #(
    .DEPTH(QUEUE_DEPTH)
  ) u_step (
    .rd_entry  (ram_rdata),
    .key       (step_key),
    .pos_nz    (step_pos_nz),
    .slot      (step_slot),
    .shift     (step_shift),
    .slot_prev (step_slot_prev)
  );

  // Circular entry store, sorted from the head slot by priority.
  sipq_ram #(
    .WIDTH(sipq_pkg::ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

/* sv/sipq_checker.sv */
// Port-level checker for the priority queue core, bound to the top level.
// Depends on sipq_pkg and sorted_insert_priority_queue_core_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_insert_priority_queue_core_assert.svh"

module sipq_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input sipq_pkg::rsp_t result
);

  logic accept;
  logic empty_rsp;
  logic rsp_zero;

  assign accept    = start && !busy;
  assign empty_rsp = done && (result.status == sipq_pkg::STATUS_EMPTY);
  assign rsp_zero  = (result.occupancy == '0) && (result.out_value == '0) &&
                     (result.out_priority == '0);

  // an accepted item either starts work or answers at once
  `SIPQ_ASSERT(a_accept_moves, clk, rst, accept |=> (busy || done), "accepted item lost")

  // results are only shown once the work is over
  `SIPQ_ASSERT(a_done_idle, clk, rst, done |-> !busy, "result strobe while busy")

  // busy only rises because an item was accepted
  `SIPQ_ASSERT(a_busy_cause, clk, rst, $rose(busy) |-> $past(accept), "busy without accept")

  // an empty-queue reject carries no entry and zero occupancy
  `SIPQ_ASSERT(a_empty_rsp, clk, rst, empty_rsp |-> rsp_zero, "bad empty reject")

endmodule

bind sorted_insert_priority_queue_core sipq_checker u_sipq_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire
